// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL core.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif
`endif

// ===== rtl/rar_pkg.sv =====
package rar_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RES_W = 33;

    localparam logic [2:0] MODE_REDUCE = 3'd0;
    localparam logic [2:0] MODE_SUM    = 3'd1;
    localparam logic [2:0] MODE_DIFF   = 3'd2;
    localparam logic [2:0] MODE_PROD   = 3'd3;
    localparam logic [2:0] MODE_QUOT   = 3'd4;

endpackage

// ===== rtl/rational_arithmetic_reduce_core.sv =====
// Fraction arithmetic unit: reduce, add, subtract, multiply or divide two
// signed fractions, and reduce the result by Euclid's algorithm.
// Input channel: in_valid/in_ready with mode, a_num, a_den, b_num, b_den.
// Output channel: out_valid/out_ready with res_num, res_den, div_error.
// The front end captures a transaction, registers the cross products and
// then the unreduced pair, and holds the pair in a one-entry queue.
// The back end runs Euclid on a shared restoring divider that takes one
// quotient bit per cycle, 2*OPERAND_WIDTH+2 quotient bits per division.
// The divider sets the throughput of the back end.
// The front end accepts the next transaction while the back end works.
// When both unreduced parts are zero, div_error is set with zero results.
// Reset clears all control state; no transaction is in flight after it.
// When the receiver stalls, the result holds on the outputs, the back end
// finishes one more transaction and waits, then the queue fills, the front
// end captures one more transaction and in_ready stays low.
`include "assert_macros.svh"
module rational_arithmetic_reduce_core #(
    parameter int OPERAND_WIDTH = rar_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [2:0]          mode,
    input  logic signed [15:0]  a_num,
    input  logic signed [15:0]  a_den,
    input  logic signed [15:0]  b_num,
    input  logic signed [15:0]  b_den,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [32:0]  res_num,
    output logic signed [32:0]  res_den,
    output logic                div_error
);
    import rar_pkg::*;

    localparam int WW = 2 * OPERAND_WIDTH + 2;

    logic q_valid, q_ready;
    logic signed [WW-1:0] q_num, q_den;

    rar_front #(.OW(OPERAND_WIDTH), .WW(WW)) u_front (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .mode(mode), .a_num(a_num), .a_den(a_den), .b_num(b_num),
        .b_den(b_den), .q_valid(q_valid), .q_ready(q_ready),
        .q_num(q_num), .q_den(q_den)
    );

    rar_back #(.WW(WW)) u_back (
        .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_ready(q_ready),
        .q_num(q_num), .q_den(q_den), .out_valid(out_valid),
        .out_ready(out_ready), .res_num(res_num), .res_den(res_den),
        .div_error(div_error)
    );

    // An error result always carries zero parts.
    `ASSERT_CLK(a_err_zero, clk, rst_n, (out_valid && div_error) |-> (res_num == '0 && res_den == '0), "error result not zero")
    // A stalled result stays put.
    `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(res_num) && $stable(res_den)), "stalled result changed")

endmodule

// ===== rtl/rar_front.sv =====
module rar_front #(
    parameter int OW = rar_pkg::OPERAND_WIDTH_DEF,
    parameter int WW = 2 * OW + 2
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [2:0]           mode,
    input  logic signed [15:0]   a_num,
    input  logic signed [15:0]   a_den,
    input  logic signed [15:0]   b_num,
    input  logic signed [15:0]   b_den,
    output logic                 q_valid,
    input  logic                 q_ready,
    output logic signed [WW-1:0] q_num,
    output logic signed [WW-1:0] q_den
);
    import rar_pkg::*;

    localparam int PW = 2 * OW;

    // Operands are taken as OW-bit two's complement values.
    logic signed [OW-1:0] an, ad, bn, bd;
    logic [2:0] mode_reg;
    logic signed [OW-1:0] an_reg, ad_reg, bn_reg, bd_reg;
    logic signed [PW-1:0] p0_reg, p1_reg, p2_reg;
    logic [2:0] md2_reg;
    logic signed [OW-1:0] an2_reg, ad2_reg;
    logic [1:0] st_reg;
    logic signed [WW-1:0] qn_reg, qd_reg;
    logic qv_reg;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_SUM  = 2'd2;

    // A field wider than the operand is cut; a narrower one is zero-filled.
    function automatic logic signed [OW-1:0] trim(input logic signed [15:0] v);
        logic [15:0] u;
        u = v;
        return OW'(u);
    endfunction

    assign an = trim(a_num);
    assign ad = trim(a_den);
    assign bn = trim(b_num);
    assign bd = trim(b_den);

    assign in_ready = (st_reg == ST_IDLE);
    assign q_valid  = qv_reg;
    assign q_num    = qn_reg;
    assign q_den    = qd_reg;

    // Capture, multiply, then combine into the unreduced pair.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg <= ST_IDLE;
            qv_reg <= 1'b0;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                        st_reg <= ST_MUL;
                end
                ST_MUL:
                    st_reg <= ST_SUM;
                ST_SUM:
                begin
                    if (!qv_reg || q_ready)
                        st_reg <= ST_IDLE;
                end
                default:
                    st_reg <= ST_IDLE;
            endcase
            if (st_reg == ST_SUM && (!qv_reg || q_ready))
                qv_reg <= 1'b1;
            else if (qv_reg && q_ready)
                qv_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && in_valid)
        begin
            mode_reg <= mode;
            an_reg <= an;
            ad_reg <= ad;
            bn_reg <= bn;
            bd_reg <= bd;
        end
        if (st_reg == ST_MUL)
        begin
            md2_reg <= mode_reg;
            an2_reg <= an_reg;
            ad2_reg <= ad_reg;
            case (mode_reg)
                MODE_QUOT:
                begin
                    p0_reg <= an_reg * bd_reg;
                    p1_reg <= PW'(0);
                    p2_reg <= ad_reg * bn_reg;
                end
                MODE_PROD:
                begin
                    p0_reg <= an_reg * bn_reg;
                    p1_reg <= PW'(0);
                    p2_reg <= ad_reg * bd_reg;
                end
                default:
                begin
                    p0_reg <= an_reg * bd_reg;
                    p1_reg <= bn_reg * ad_reg;
                    p2_reg <= ad_reg * bd_reg;
                end
            endcase
        end
        if (st_reg == ST_SUM && (!qv_reg || q_ready))
        begin
            case (md2_reg) inside
                MODE_SUM:
                begin
                    qn_reg <= WW'(p0_reg) + WW'(p1_reg);
                    qd_reg <= WW'(p2_reg);
                end
                MODE_DIFF:
                begin
                    qn_reg <= WW'(p0_reg) - WW'(p1_reg);
                    qd_reg <= WW'(p2_reg);
                end
                MODE_PROD, MODE_QUOT:
                begin
                    qn_reg <= WW'(p0_reg);
                    qd_reg <= WW'(p2_reg);
                end
                default:
                begin
                    qn_reg <= WW'(an2_reg);
                    qd_reg <= WW'(ad2_reg);
                end
            endcase
        end
    end

endmodule

// ===== rtl/rar_divider.sv =====
module rar_divider #(
    parameter int WW = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic signed [WW-1:0] dividend,
    input  logic signed [WW-1:0] divisor,
    output logic                 done,
    output logic signed [WW-1:0] quotient,
    output logic signed [WW-1:0] remainder
);
    import rar_pkg::*;

    localparam int CW = $clog2(WW + 1);

    // Restoring division on magnitudes, one quotient bit per cycle.
    logic [WW-1:0] rem_reg, quo_reg, dsr_reg;
    logic [CW-1:0] cnt_reg;
    logic busy_reg, done_reg, qneg_reg, rneg_reg;
    logic [WW:0] trial;
    logic [WW-1:0] shifted;

    assign shifted = {rem_reg[WW-2:0], quo_reg[WW-1]};
    assign trial = {1'b0, shifted} - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(WW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                    busy_reg <= 1'b0;
            end
            // Done pulses for one cycle after the last quotient bit.
            done_reg <= busy_reg && !start && (cnt_reg == CW'(1));
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            quo_reg  <= dividend[WW-1] ? WW'(-dividend) : dividend;
            dsr_reg  <= divisor[WW-1] ? WW'(-divisor) : divisor;
            qneg_reg <= dividend[WW-1] ^ divisor[WW-1];
            rneg_reg <= dividend[WW-1];
        end
        else if (busy_reg)
        begin
            if (!trial[WW])
            begin
                rem_reg <= trial[WW-1:0];
                quo_reg <= {quo_reg[WW-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted;
                quo_reg <= {quo_reg[WW-2:0], 1'b0};
            end
        end
    end

    assign done      = done_reg;
    assign quotient  = qneg_reg ? WW'(-quo_reg) : quo_reg;
    assign remainder = rneg_reg ? WW'(-rem_reg) : rem_reg;

endmodule

// ===== rtl/rar_back.sv =====
module rar_back #(
    parameter int WW = 34
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  logic signed [WW-1:0] q_num,
    input  logic signed [WW-1:0] q_den,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic signed [32:0]   res_num,
    output logic signed [32:0]   res_den,
    output logic                 div_error
);
    import rar_pkg::*;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EUC  = 3'd1;
    localparam logic [2:0] ST_EWT  = 3'd2;
    localparam logic [2:0] ST_DN   = 3'd3;
    localparam logic [2:0] ST_DD   = 3'd4;
    localparam logic [2:0] ST_OUT  = 3'd5;

    logic [2:0] st_reg;
    logic signed [WW-1:0] n_reg, d_reg, x_reg, y_reg;
    logic signed [RES_W-1:0] rn_reg, rd_reg;
    logic signed [RES_W-1:0] out_num_reg, out_den_reg;
    logic err_reg, out_err_reg, ov_reg;
    logic dv_start;
    logic signed [WW-1:0] dv_a, dv_b, dv_q, dv_r;
    logic dv_done;

    rar_divider #(.WW(WW)) u_div (
        .clk(clk), .rst_n(rst_n), .start(dv_start),
        .dividend(dv_a), .divisor(dv_b),
        .done(dv_done), .quotient(dv_q), .remainder(dv_r)
    );

    assign q_ready   = (st_reg == ST_IDLE);
    assign out_valid = ov_reg;
    assign res_num   = out_num_reg;
    assign res_den   = out_den_reg;
    assign div_error = out_err_reg;

    // Divider operands follow the sequencer step.
    always_comb
    begin
        dv_start = 1'b0;
        dv_a = x_reg;
        dv_b = y_reg;
        unique case (st_reg)
            ST_EUC: dv_start = (y_reg != '0);
            ST_DN:  begin dv_start = 1'b1; dv_a = n_reg; dv_b = x_reg; end
            ST_DD:  begin dv_start = 1'b1; dv_a = d_reg; dv_b = x_reg; end
            default: dv_start = 1'b0;
        endcase
    end

    // Euclid loop on the shared divider, then two exact divisions; 0/0 skips both.
    logic [1:0] sub_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg  <= ST_IDLE;
            ov_reg  <= 1'b0;
            sub_reg <= 2'd0;
        end
        else
        begin
            unique case (st_reg)
                ST_IDLE:
                    if (q_valid)
                        st_reg <= ST_EUC;
                ST_EUC:
                begin
                    if (n_reg == '0 && d_reg == '0)
                        st_reg <= ST_OUT;
                    else if (y_reg == '0)
                        st_reg <= ST_DN;
                    else
                        st_reg <= ST_EWT;
                end
                ST_EWT:
                    if (dv_done)
                        st_reg <= (sub_reg == 2'd1) ? ST_DD
                                : (sub_reg == 2'd2) ? ST_OUT : ST_EUC;
                ST_DN:
                begin
                    sub_reg <= 2'd1;
                    st_reg  <= ST_EWT;
                end
                ST_DD:
                begin
                    sub_reg <= 2'd2;
                    st_reg  <= ST_EWT;
                end
                ST_OUT:
                    if (!ov_reg || out_ready)
                    begin
                        sub_reg <= 2'd0;
                        st_reg  <= ST_IDLE;
                    end
                default:
                    st_reg <= ST_IDLE;
            endcase
            if (st_reg == ST_OUT && (!ov_reg || out_ready))
                ov_reg <= 1'b1;
            else if (ov_reg && out_ready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (st_reg == ST_IDLE && q_valid)
        begin
            n_reg <= q_num;
            d_reg <= q_den;
            x_reg <= q_num;
            y_reg <= q_den;
            err_reg <= 1'b0;
            rn_reg <= '0;
            rd_reg <= '0;
        end
        if (st_reg == ST_EUC && n_reg == '0 && d_reg == '0)
            err_reg <= 1'b1;
        if (st_reg == ST_EWT && dv_done)
        begin
            case (sub_reg)
                2'd1: rn_reg <= RES_W'(dv_q);
                2'd2: rd_reg <= RES_W'(dv_q);
                default:
                begin
                    x_reg <= y_reg;
                    y_reg <= dv_r;
                end
            endcase
        end
        // The output register keeps a stalled result while the next one is worked on.
        if (st_reg == ST_OUT && (!ov_reg || out_ready))
        begin
            out_num_reg <= rn_reg;
            out_den_reg <= rd_reg;
            out_err_reg <= err_reg;
        end
    end

endmodule

// ===== tb/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rar_pkg::*;

    // Reduced fraction as the block should report it.
    typedef struct packed {
        logic signed [32:0] num;
        logic signed [32:0] den;
        logic               err;
    } fraction_t;

    // One row of the directed table.
    typedef struct {
        logic [2:0]         op;
        logic signed [15:0] an;
        logic signed [15:0] ad;
        logic signed [15:0] bn;
        logic signed [15:0] bd;
        bit                 fixed;
        fraction_t          want;
    } vector_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [2:0]         mode;
    logic signed [15:0] a_num;
    logic signed [15:0] a_den;
    logic signed [15:0] b_num;
    logic signed [15:0] b_den;
    logic               out_valid;
    logic               out_ready;
    logic signed [32:0] res_num;
    logic signed [32:0] res_den;
    logic               div_error;

    // Typed-in answer that travels with the current transaction, if any.
    bit        row_fixed;
    fraction_t row_want;

    fraction_t reduced_q[$];
    int        errors;
    int        results_seen;
    int        zero_pairs_seen;
    int        mode_count[8];
    bit        steady;
    int        ready_wait;

    rational_arithmetic_reduce_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .mode      (mode),
        .a_num     (a_num),
        .a_den     (a_den),
        .b_num     (b_num),
        .b_den     (b_den),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .res_num   (res_num),
        .res_den   (res_den),
        .div_error (div_error)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Form the mode's pair, then divide both by Euclid's last non-zero remainder.
    function automatic fraction_t reduce_fraction(logic [2:0] op, logic signed [15:0] an,
                                                  logic signed [15:0] ad,
                                                  logic signed [15:0] bn,
                                                  logic signed [15:0] bd);
        longint    n;
        longint    d;
        longint    x;
        longint    y;
        longint    r;
        fraction_t f;
        case (op)
            MODE_SUM:
            begin
                n = longint'(an) * bd + longint'(bn) * ad;
                d = longint'(ad) * bd;
            end
            MODE_DIFF:
            begin
                n = longint'(an) * bd - longint'(bn) * ad;
                d = longint'(ad) * bd;
            end
            MODE_PROD:
            begin
                n = longint'(an) * bn;
                d = longint'(ad) * bd;
            end
            MODE_QUOT:
            begin
                n = longint'(an) * bd;
                d = longint'(ad) * bn;
            end
            default:
            begin
                n = an;
                d = ad;
            end
        endcase
        if (n == 0 && d == 0)
        begin
            f.num = '0;
            f.den = '0;
            f.err = 1'b1;
            return f;
        end
        x = n;
        y = d;
        while (y != 0)
        begin
            r = x % y;
            x = y;
            y = r;
        end
        f.num = 33'(n / x);
        f.den = 33'(d / x);
        f.err = 1'b0;
        return f;
    endfunction

    // Record the expected result of every accepted transaction.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && in_ready)
        begin
            reduced_q.push_back(row_fixed ? row_want
                                          : reduce_fraction(mode, a_num, a_den, b_num, b_den));
            mode_count[mode] = mode_count[mode] + 1;
        end
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        fraction_t w;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen = results_seen + 1;
            if (reduced_q.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: result %0d/%0d err=%0b with no transaction pending",
                         $time, res_num, res_den, div_error);
            end
            else
            begin
                w = reduced_q.pop_front();
                if (w.err)
                    zero_pairs_seen = zero_pairs_seen + 1;
                if (res_num !== w.num)
                begin
                    errors = errors + 1;
                    $display("%0t: res_num expected %0d actual %0d", $time, w.num, res_num);
                end
                if (res_den !== w.den)
                begin
                    errors = errors + 1;
                    $display("%0t: res_den expected %0d actual %0d", $time, w.den, res_den);
                end
                if (div_error !== w.err)
                begin
                    errors = errors + 1;
                    $display("%0t: div_error expected %0b actual %0b", $time, w.err, div_error);
                end
            end
        end
    end

    // The receiver stalls at random after each result, but not in steady stretches.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            ready_wait = 0;
        end
        else
        begin
            if (out_valid && out_ready)
                ready_wait = steady ? 0 : $urandom_range(0, 4);
            else if (ready_wait > 0)
                ready_wait = ready_wait - 1;
            out_ready <= (ready_wait == 0);
        end
    end

    // Present one transaction after a random gap and wait until it is taken.
    task automatic send_fraction(vector_t v);
        int gap;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= v.op;
        a_num     <= v.an;
        a_den     <= v.ad;
        b_num     <= v.bn;
        b_den     <= v.bd;
        row_fixed <= v.fixed;
        row_want  <= v.want;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    function automatic logic signed [15:0] pick_operand();
        case ($urandom_range(0, 9)) inside
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2:       return 16'sd0;
            3, 4:    return 16'($signed($urandom_range(0, 40)) - 20);
            5:       return 16'(($urandom_range(0, 200) - 100) * 12);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic vector_t row(logic [2:0] op, int an, int ad, int bn, int bd);
        vector_t v;
        v.op    = op;
        v.an    = 16'(an);
        v.ad    = 16'(ad);
        v.bn    = 16'(bn);
        v.bd    = 16'(bd);
        v.fixed = 1'b0;
        v.want  = '0;
        return v;
    endfunction

    function automatic vector_t known(vector_t v, int n, int d, bit e);
        v.fixed    = 1'b1;
        v.want.num = 33'(n);
        v.want.den = 33'(d);
        v.want.err = e;
        return v;
    endfunction

    initial
    begin
        vector_t table_rows[$];
        vector_t v;
        int      k;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        mode       = MODE_REDUCE;
        a_num      = '0;
        a_den      = '0;
        b_num      = '0;
        b_den      = '0;
        row_fixed  = 1'b0;
        row_want   = '0;
        errors     = 0;
        results_seen    = 0;
        zero_pairs_seen = 0;
        steady     = 1'b0;
        foreach (mode_count[i])
            mode_count[i] = 0;

        // Directed rows: both parts zero, zero denominator, extremes, odd modes.
        table_rows.push_back(known(row(MODE_REDUCE, 0, 0, 5, 7), 0, 0, 1'b1));
        table_rows.push_back(known(row(MODE_REDUCE, 7, 0, 0, 0), 1, 0, 1'b0));
        table_rows.push_back(known(row(MODE_REDUCE, 6, 4, 0, 0), 3, 2, 1'b0));
        table_rows.push_back(known(row(MODE_SUM, 3, 0, 4, 0), 0, 0, 1'b1));
        table_rows.push_back(known(row(MODE_PROD, 0, 0, 9, 9), 0, 0, 1'b1));
        table_rows.push_back(known(row(MODE_QUOT, 0, 5, 0, 3), 0, 0, 1'b1));
        table_rows.push_back(known(row(3'd5, 0, 0, 1, 1), 0, 0, 1'b1));
        table_rows.push_back(row(MODE_REDUCE, -6, 4, 0, 0));
        table_rows.push_back(row(MODE_REDUCE, 32767, -32768, 0, 0));
        table_rows.push_back(row(MODE_REDUCE, -32768, -32768, 0, 0));
        table_rows.push_back(row(MODE_SUM, 1, 2, 1, 3));
        table_rows.push_back(row(MODE_SUM, 32767, -32768, 32767, -32768));
        table_rows.push_back(row(MODE_SUM, -32768, 32767, -32768, 32767));
        table_rows.push_back(row(MODE_DIFF, 1, 2, 1, 2));
        table_rows.push_back(row(MODE_DIFF, -32768, 32767, 32767, -32768));
        table_rows.push_back(row(MODE_PROD, -32768, 32767, -32768, 32767));
        table_rows.push_back(row(MODE_PROD, 2, -3, -9, 4));
        table_rows.push_back(row(MODE_QUOT, 32767, -32768, -32768, 32767));
        table_rows.push_back(row(MODE_QUOT, 5, 1, 0, 2));
        table_rows.push_back(row(3'd6, -15, 25, 3, 3));
        table_rows.push_back(row(3'd7, 21, -14, -1, -1));
        table_rows.push_back(row(MODE_SUM, -1, -1, -1, -1));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (table_rows[i])
            send_fraction(table_rows[i]);

        // Hold the sender off until every outstanding result has drained.
        in_valid <= 1'b0;
        while (reduced_q.size() != 0)
            @(posedge clk);
        @(posedge clk);

        // Random part, with some stretches where neither side idles.
        for (k = 0; k < 1500; k++)
        begin
            if (k % 250 == 0)
                steady = ($urandom_range(0, 2) == 0);
            v.op = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
                                                : 3'($urandom_range(0, 4));
            v.an = pick_operand();
            v.ad = pick_operand();
            v.bn = pick_operand();
            v.bd = pick_operand();
            v.fixed = 1'b0;
            v.want  = '0;
            send_fraction(v);
        end
        in_valid <= 1'b0;

        while (reduced_q.size() != 0)
            @(posedge clk);
        repeat (3000) @(posedge clk);

        $display("Checked %0d results (%0d with both parts zero); per mode 0..7: %0d %0d %0d %0d %0d %0d %0d %0d",
                 results_seen, zero_pairs_seen, mode_count[0], mode_count[1], mode_count[2],
                 mode_count[3], mode_count[4], mode_count[5], mode_count[6], mode_count[7]);
        if (errors == 0 && reduced_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #100ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule
